>>> hdl/rfr_pkg.sv
// Shared types and constants for the remote frame receiver.
package rfr_pkg;

    // Parser phases of the frame hunt.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR2,
        PH_DATA,
        PH_TRL1,
        PH_TRL2,
        PH_CHECK
    } t_phase;

    // Framing bytes.
    localparam logic [7:0] HDR_LEAD   = 8'hE0;
    localparam logic [7:0] HDR_SECOND = 8'h01;
    localparam logic [7:0] TRL_ZERO   = 8'h00;
    localparam logic [7:0] TRL_LAST   = 8'hE0;

    // The checksum is kept reduced modulo this value.
    localparam logic [8:0] SUM_MOD = 9'd255;

    // Scaling of the derived outputs.
    localparam logic signed [19:0] SPEED_GAIN  = 20'sd11;
    localparam logic signed [20:0] CENTER_GAIN = 21'sd27;
    localparam logic signed [20:0] CENTER_ROUND = 21'sd32767;
    localparam logic [6:0]         CENTER_BIAS = 7'd64;

    // Depth of the queue between the parser and the output stage.
    localparam int MID_DEPTH = 2;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

    // One accepted frame as handed from the parser to the output stage.
    typedef struct packed {
        logic [15:0] word_zero;
        logic [15:0] word_one;
        logic [15:0] word_two;
        logic [15:0] word_three;
        logic [15:0] word_four;
        logic [3:0]  mode_bits;
    } t_frame;

    // Handshake from the queue head toward the output stage.
    typedef struct packed {
        logic   empty;
        t_frame head;
    } t_mid_head;

endpackage

>>> hdl/remote_frame_receiver_core.sv
// Top level of the remote frame receiver: parser, frame queue and output stage.
// Throughput: one received byte per cycle while full is low; full shows the frame queue is full.
// A frame's result shows on the outputs (empty low) after the edge that accepts its checksum
// beat writes it to the frame queue and the output register then loads it once free or popped.
// Reset (synchronous, active low) returns the parser to the hunt for a leading E0 and empties
// the frame queue and the output register; the payload store itself is not cleared.
module remote_frame_receiver_core #(
    parameter int PAYLOAD_BYTES = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        o_word_zero,
    output logic [15:0]        o_word_one,
    output logic [15:0]        o_word_two,
    output logic [15:0]        o_word_three,
    output logic [15:0]        o_word_four,
    output logic [3:0]         o_mode_bits,
    output logic signed [19:0] o_speed_scaled,
    output logic [6:0]         o_center_line
);

    // A beat is taken whenever the frame queue has room. The parser only pushes on the
    // checksum beat of a good frame, so holding off input on a full queue never loses one.
    logic               in_accept;
    logic               frame_push;
    rfr_pkg::t_frame    frame;
    rfr_pkg::t_mid_head mid_head;
    logic               mid_pop;

    assign in_accept = push && !full;

    // The parser keeps the phase, the running sum modulo 255, the byte index and the
    // payload bytes, and forms the five little-endian words and the mode nibble.
    rfr_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (frame_push),
        .o_frame   (frame)
    );

    // The queue lets the parser keep taking bytes while a result waits to be popped.
    rfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (frame_push),
        .i_frame (frame),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_head  (mid_head)
    );

    // The output stage scales speed and center line and holds the result until popped.
    rfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (mid_head),
        .o_mid_pop      (mid_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_word_zero    (o_word_zero),
        .o_word_one     (o_word_one),
        .o_word_two     (o_word_two),
        .o_word_three   (o_word_three),
        .o_word_four    (o_word_four),
        .o_mode_bits    (o_mode_bits),
        .o_speed_scaled (o_speed_scaled),
        .o_center_line  (o_center_line)
    );

endmodule

>>> hdl/rfr_front.sv
// Frame parser: hunts for framed payloads, checks the sum and emits good frames.
module rfr_front #(
    parameter int PAYLOAD_BYTES = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output rfr_pkg::t_frame   o_frame
);

    localparam int IDX_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int ADDR_W = $clog2(PAYLOAD_BYTES);

    rfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [IDX_W-1:0] r_index, n_index;
    logic [7:0]       r_store [PAYLOAD_BYTES];

    logic [IDX_W-1:0] index_inc;
    logic [8:0]       sum_raw;
    logic [7:0]       sum_add;
    logic             store_wr;

    assign index_inc = r_index + 1'b1;
    assign sum_raw   = {1'b0, r_sum} + {1'b0, i_rx_byte};
    assign sum_add   = (sum_raw >= rfr_pkg::SUM_MOD) ? 8'(sum_raw - rfr_pkg::SUM_MOD)
                                                     : sum_raw[7:0];

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                rfr_pkg::PH_HUNT: begin
                    if (i_rx_byte == rfr_pkg::HDR_LEAD) n_phase = rfr_pkg::PH_HDR2;
                end
                rfr_pkg::PH_HDR2: begin
                    n_phase = (i_rx_byte == rfr_pkg::HDR_SECOND) ? rfr_pkg::PH_DATA
                                                                 : rfr_pkg::PH_HUNT;
                end
                rfr_pkg::PH_DATA: begin
                    if (index_inc == IDX_W'(PAYLOAD_BYTES)) n_phase = rfr_pkg::PH_TRL1;
                end
                rfr_pkg::PH_TRL1: begin
                    if (i_rx_byte == rfr_pkg::TRL_ZERO) n_phase = rfr_pkg::PH_TRL2;
                end
                rfr_pkg::PH_TRL2: begin
                    n_phase = (i_rx_byte == rfr_pkg::TRL_LAST) ? rfr_pkg::PH_CHECK
                                                               : rfr_pkg::PH_HUNT;
                end
                default: n_phase = rfr_pkg::PH_HUNT;
            endcase
        end
    end

    // Sum, index, store write and frame push.
    always_comb begin
        n_sum    = r_sum;
        n_index  = r_index;
        store_wr = 1'b0;
        o_push   = 1'b0;
        if (i_accept) begin
            case (r_phase)
                rfr_pkg::PH_HUNT: begin
                    if (i_rx_byte == rfr_pkg::HDR_LEAD) begin
                        n_sum   = i_rx_byte;
                        n_index = '0;
                    end
                end
                rfr_pkg::PH_HDR2: begin
                    if (i_rx_byte == rfr_pkg::HDR_SECOND) n_sum = sum_add;
                end
                rfr_pkg::PH_DATA: begin
                    n_sum    = sum_add;
                    n_index  = index_inc;
                    store_wr = 1'b1;
                end
                rfr_pkg::PH_TRL1: begin
                    // Bytes other than the zero are skipped without leaving the frame.
                    if (i_rx_byte == rfr_pkg::TRL_ZERO) begin
                        n_sum   = sum_add;
                        n_index = '0;
                    end
                end
                rfr_pkg::PH_TRL2: begin
                    if (i_rx_byte == rfr_pkg::TRL_LAST) n_sum = sum_add;
                end
                rfr_pkg::PH_CHECK: begin
                    if (i_rx_byte == r_sum) begin
                        o_push = 1'b1;
                        n_sum  = '0;
                    end
                end
                default: n_sum = r_sum;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rfr_pkg::PH_HUNT;
            r_sum   <= '0;
            r_index <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) r_store[r_index[ADDR_W-1:0]] <= i_rx_byte;
    end

    assign o_frame.word_zero  = {r_store[1], r_store[0]};
    assign o_frame.word_one   = {r_store[3], r_store[2]};
    assign o_frame.word_two   = {r_store[5], r_store[4]};
    assign o_frame.word_three = {r_store[7], r_store[6]};
    assign o_frame.word_four  = {r_store[9], r_store[8]};
    assign o_frame.mode_bits  = r_store[10][3:0];

endmodule

>>> hdl/rfr_queue.sv
// Short frame queue between the parser and the output stage.
module rfr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rfr_pkg::t_frame     i_frame,
    output logic                o_full,
    input  logic                i_pop,
    output rfr_pkg::t_mid_head  o_head
);

    rfr_pkg::t_frame                r_mem [rfr_pkg::MID_DEPTH];
    logic [rfr_pkg::MID_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [rfr_pkg::MID_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [rfr_pkg::MID_CNT_W-1:0]  r_count, n_count;
    logic                           do_push, do_pop;

    assign o_full       = (r_count == rfr_pkg::MID_CNT_W'(rfr_pkg::MID_DEPTH));
    assign o_head.empty = (r_count == '0);
    assign o_head.head  = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && !o_head.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == rfr_pkg::MID_PTR_W'(rfr_pkg::MID_DEPTH - 1)) ? '0
                                                                              : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == rfr_pkg::MID_PTR_W'(rfr_pkg::MID_DEPTH - 1)) ? '0
                                                                              : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_frame;
    end

endmodule

>>> hdl/rfr_back.sv
// Output stage: derives speed and center line and holds the result register.
module rfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rfr_pkg::t_mid_head i_head,
    output logic               o_mid_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [15:0]        o_word_zero,
    output logic [15:0]        o_word_one,
    output logic [15:0]        o_word_two,
    output logic [15:0]        o_word_three,
    output logic [15:0]        o_word_four,
    output logic [3:0]         o_mode_bits,
    output logic signed [19:0] o_speed_scaled,
    output logic [6:0]         o_center_line
);

    logic                r_valid, n_valid;
    rfr_pkg::t_frame     r_frame;
    logic signed [19:0]  r_speed, n_speed;
    logic [6:0]          r_center, n_center;

    logic signed [19:0]  spd_ext;
    logic signed [20:0]  ctr_ext, ctr_prod, ctr_adj;
    logic signed [5:0]   ctr_quo;

    // Offset-binary to two's complement is a flip of the top bit.
    assign spd_ext = {{4{~i_head.head.word_four[15]}}, ~i_head.head.word_four[15],
                      i_head.head.word_four[14:0]};
    assign n_speed = spd_ext * rfr_pkg::SPEED_GAIN;

    assign ctr_ext  = {{5{~i_head.head.word_two[15]}}, ~i_head.head.word_two[15],
                       i_head.head.word_two[14:0]};
    assign ctr_prod = ctr_ext * rfr_pkg::CENTER_GAIN;
    // Bias negative values so the shift truncates toward zero.
    assign ctr_adj  = ctr_prod + (ctr_prod[20] ? rfr_pkg::CENTER_ROUND : 21'sd0);
    assign ctr_quo  = ctr_adj[20:15];
    assign n_center = rfr_pkg::CENTER_BIAS + {ctr_quo[5], ctr_quo};

    assign o_mid_pop = !i_head.empty && (!r_valid || i_pop);
    assign n_valid   = o_mid_pop || (r_valid && !i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_frame  <= i_head.head;
            r_speed  <= n_speed;
            r_center <= n_center;
        end
    end

    assign o_empty        = !r_valid;
    assign o_word_zero    = r_frame.word_zero;
    assign o_word_one     = r_frame.word_one;
    assign o_word_two     = r_frame.word_two;
    assign o_word_three   = r_frame.word_three;
    assign o_word_four    = r_frame.word_four;
    assign o_mode_bits    = r_frame.mode_bits;
    assign o_speed_scaled = r_speed;
    assign o_center_line  = r_center;

endmodule
